// ----- rtl/fjsv_pkg.sv -----
// ----------------------------------------------------------------------------
// fjsv_pkg
// Types, template text and character codes for the JSON state validator.
// ----------------------------------------------------------------------------
package fjsv_pkg;

  localparam int TMPL_LEN    = 100;
  localparam int POS_W       = 7;
  localparam int NUM_SMALL   = 6;
  localparam int SLOT_W      = 3;
  localparam int TEXT_W      = 12;
  localparam int MODE_LEN_W  = 3;
  localparam int WORD_LEN    = 6;
  localparam int ACC_W       = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [SLOT_W-1:0] VERSION_SLOT = SLOT_W'(NUM_SMALL);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_DIM    = 2'd0,
    REG_MAX_CELLS  = 2'd1,
    REG_MAX_BRIGHT = 2'd2,
    REG_MAX_TEXT   = 2'd3
  } cfg_reg_t;

  localparam logic [7:0] RST_MAX_DIM    = 8'd128;
  localparam logic [15:0] RST_MAX_CELLS = 16'd4096;
  localparam logic [7:0] RST_MAX_BRIGHT = 8'd100;
  localparam logic [11:0] RST_MAX_TEXT  = 12'd1023;

  localparam logic [8*TMPL_LEN-1:0] TMPL =
    {"{\"type\":\"state\",\"width\":#,\"height\":#,\"text\":\"$,\"color\":[#,#,#],",
     "\"brightness\":#,\"mode\":\"@,\"version\":#}"};

  localparam logic [8*WORD_LEN-1:0] WORD_STATIC = "static";
  localparam logic [8*WORD_LEN-1:0] WORD_SCROLL = "scroll";

  localparam logic [7:0] CH_NUM    = "#";
  localparam logic [7:0] CH_TEXT   = "$";
  localparam logic [7:0] CH_MODE   = "@";
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_LOW_B  = "b";
  localparam logic [7:0] CH_LOW_F  = "f";
  localparam logic [7:0] CH_LOW_N  = "n";
  localparam logic [7:0] CH_LOW_R  = "r";
  localparam logic [7:0] CH_LOW_T  = "t";
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_NINE   = "9";
  localparam logic [7:0] CH_CTRL   = 8'h20;
  localparam logic [7:0] CH_END    = 8'h00;

  typedef struct packed {
    logic              shape_ok;
    logic [7:0]        width;
    logic [7:0]        height;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        brightness;
    logic              scroll;
    logic [ACC_W-1:0]  version;
  } fjsv_sum_t;

  typedef struct packed {
    logic [7:0]  max_dim;
    logic [15:0] max_cells;
    logic [7:0]  max_bright;
    logic [11:0] max_text;
  } fjsv_cfg_t;

  function automatic logic [7:0] tmpl_char(input logic [POS_W-1:0] pos);
    logic [7:0] ch;
    ch = CH_END;
    if (int'(pos) < TMPL_LEN) begin
      ch = TMPL[8*(TMPL_LEN-1-int'(pos)) +: 8];
    end
    return ch;
  endfunction

  function automatic logic [7:0] word_char(input logic [8*WORD_LEN-1:0] word,
                                           input logic [MODE_LEN_W-1:0] idx);
    logic [7:0] ch;
    ch = CH_END;
    if (int'(idx) < WORD_LEN) begin
      ch = word[8*(WORD_LEN-1-int'(idx)) +: 8];
    end
    return ch;
  endfunction

endpackage

// ----- rtl/fjsv_if.sv -----
// ----------------------------------------------------------------------------
// fjsv interfaces
// Payload, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fjsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface fjsv_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [7:0]  width_out;
  logic [7:0]  height_out;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [7:0]  brightness_out;
  logic        mode_scroll;
  logic [63:0] version_out;

  modport source (output valid, valid_res, width_out, height_out, red_out, green_out,
                  blue_out, brightness_out, mode_scroll, version_out, input ready);
  modport sink (input valid, valid_res, width_out, height_out, red_out, green_out,
                blue_out, brightness_out, mode_scroll, version_out, output ready);
endinterface

interface fjsv_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/fjsv_cfg.sv -----
// ----------------------------------------------------------------------------
// fjsv_cfg
// Limit registers written through the configuration channel.
// ----------------------------------------------------------------------------
module fjsv_cfg
  import fjsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  fjsv_cfg_if.sink    cfg,
  output fjsv_cfg_t   limits
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.max_dim    <= RST_MAX_DIM;
      limits.max_cells  <= RST_MAX_CELLS;
      limits.max_bright <= RST_MAX_BRIGHT;
      limits.max_text   <= RST_MAX_TEXT;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_MAX_DIM:    limits.max_dim    <= cfg.data[7:0];
        REG_MAX_CELLS:  limits.max_cells  <= cfg.data;
        REG_MAX_BRIGHT: limits.max_bright <= cfg.data[7:0];
        REG_MAX_TEXT:   limits.max_text   <= cfg.data[11:0];
      endcase
    end
  end

endmodule

// ----- rtl/fjsv_parser.sv -----
// ----------------------------------------------------------------------------
// fjsv_parser
// Template walker: matches one word per step and keeps the parse state.
// ----------------------------------------------------------------------------
module fjsv_parser
  import fjsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [11:0] max_text,
  output fjsv_sum_t   sum
);

  logic [POS_W-1:0]      pos, pos_next;
  logic [ACC_W-1:0]      acc, acc_next;
  logic                  seen, seen_next;
  logic [SLOT_W-1:0]     slot, slot_next;
  logic [7:0]            fields [NUM_SMALL];
  logic [7:0]            fields_next [NUM_SMALL];
  logic [ACC_W-1:0]      version, version_next;
  logic [TEXT_W-1:0]     tcount, tcount_next;
  logic                  esc, esc_next;
  logic [MODE_LEN_W-1:0] mlen, mlen_next;
  logic [1:0]            mmatch, mmatch_next;
  logic                  failed, failed_next;
  logic                  term, term_next;

  logic [7:0]            t_cur, t_after;
  logic                  digit;
  logic [ACC_W+3:0]      prod;
  logic [TEXT_W:0]       tsum;
  logic                  esc_ok;
  logic                  commit_bad;

  always_comb begin
    pos_next     = pos;
    acc_next     = acc;
    seen_next    = seen;
    slot_next    = slot;
    fields_next  = fields;
    version_next = version;
    tcount_next  = tcount;
    esc_next     = esc;
    mlen_next    = mlen;
    mmatch_next  = mmatch;
    failed_next  = failed;
    term_next    = term;

    t_cur   = tmpl_char(pos);
    t_after = tmpl_char(pos + POS_W'(1));
    digit   = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    prod    = {acc, 3'b000} + {3'b000, acc, 1'b0} + (ACC_W+4)'(data_byte - CH_ZERO);
    tsum    = {1'b0, tcount} + (TEXT_W+1)'(1);
    commit_bad = (slot != VERSION_SLOT) && (acc[ACC_W-1:8] != '0);

    case (data_byte) inside
      CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LOW_B, CH_LOW_F, CH_LOW_N, CH_LOW_R,
      CH_LOW_T: esc_ok = 1'b1;
      default:  esc_ok = 1'b0;
    endcase

    if (!term) begin
      if (data_byte == CH_END) begin
        term_next = 1'b1;
      end else if (!failed) begin
        if (int'(pos) >= TMPL_LEN) begin
          failed_next = 1'b1;
        end else if (t_cur == CH_NUM) begin
          if (digit) begin
            if (prod[ACC_W+3:ACC_W] != '0) begin
              failed_next = 1'b1;
            end else begin
              acc_next  = prod[ACC_W-1:0];
              seen_next = 1'b1;
            end
          end else if (!seen) begin
            failed_next = 1'b1;
          end else begin
            acc_next  = '0;
            seen_next = 1'b0;
            slot_next = slot + SLOT_W'(1);
            if (slot == VERSION_SLOT) begin
              version_next = acc;
            end
            for (int i = 0; i < NUM_SMALL; i++) begin
              if (slot == SLOT_W'(i)) begin
                fields_next[i] = acc[7:0];
              end
            end
            if (commit_bad || data_byte != t_after) begin
              failed_next = 1'b1;
            end else begin
              pos_next = pos + POS_W'(2);
            end
          end
        end else if (t_cur == CH_TEXT) begin
          if (esc) begin
            esc_next = 1'b0;
            if (!esc_ok) begin
              failed_next = 1'b1;
            end else begin
              tcount_next = tsum[TEXT_W-1:0];
              if (tsum > {1'b0, max_text}) failed_next = 1'b1;
            end
          end else if (data_byte == CH_QUOTE) begin
            pos_next = pos + POS_W'(1);
          end else if (data_byte < CH_CTRL) begin
            failed_next = 1'b1;
          end else if (data_byte == CH_BSLASH) begin
            esc_next = 1'b1;
          end else begin
            tcount_next = tsum[TEXT_W-1:0];
            if (tsum > {1'b0, max_text}) failed_next = 1'b1;
          end
        end else if (t_cur == CH_MODE) begin
          if (data_byte == CH_QUOTE) begin
            if (int'(mlen) == WORD_LEN && mmatch != 2'b00) begin
              pos_next = pos + POS_W'(1);
            end else begin
              failed_next = 1'b1;
            end
          end else if (int'(mlen) >= WORD_LEN) begin
            failed_next = 1'b1;
          end else begin
            if (data_byte != word_char(WORD_STATIC, mlen)) mmatch_next[0] = 1'b0;
            if (data_byte != word_char(WORD_SCROLL, mlen)) mmatch_next[1] = 1'b0;
            mlen_next = mlen + MODE_LEN_W'(1);
          end
        end else if (data_byte == t_cur) begin
          pos_next = pos + POS_W'(1);
        end else begin
          failed_next = 1'b1;
        end
      end
    end
  end

  always_comb begin
    sum.shape_ok   = !failed_next && (int'(pos_next) == TMPL_LEN);
    sum.width      = fields_next[0];
    sum.height     = fields_next[1];
    sum.red        = fields_next[2];
    sum.green      = fields_next[3];
    sum.blue       = fields_next[4];
    sum.brightness = fields_next[5];
    sum.scroll     = mmatch_next[1];
    sum.version    = version_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      pos     <= '0;
      acc     <= '0;
      seen    <= 1'b0;
      slot    <= '0;
      for (int i = 0; i < NUM_SMALL; i++) fields[i] <= '0;
      version <= '0;
      tcount  <= '0;
      esc     <= 1'b0;
      mlen    <= '0;
      mmatch  <= 2'b11;
      failed  <= 1'b0;
      term    <= 1'b0;
    end else if (step) begin
      pos     <= pos_next;
      acc     <= acc_next;
      seen    <= seen_next;
      slot    <= slot_next;
      fields  <= fields_next;
      version <= version_next;
      tcount  <= tcount_next;
      esc     <= esc_next;
      mlen    <= mlen_next;
      mmatch  <= mmatch_next;
      failed  <= failed_next;
      term    <= term_next;
    end
  end

endmodule

// ----- rtl/fjsv_judge.sv -----
// ----------------------------------------------------------------------------
// fjsv_judge
// Final range checks and the result register.
// ----------------------------------------------------------------------------
module fjsv_judge
  import fjsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  fjsv_sum_t   sum,
  input  fjsv_cfg_t   limits,
  output logic        slot_free,
  fjsv_out_if.source  result
);

  logic        ok;
  logic [15:0] cells;

  always_comb begin
    cells = 16'(sum.width) * 16'(sum.height);
    ok = sum.shape_ok &&
         (sum.width != '0) && (sum.width <= limits.max_dim) &&
         (sum.height != '0) && (sum.height <= limits.max_dim) &&
         (cells <= limits.max_cells) && (sum.brightness <= limits.max_bright);
  end

  assign slot_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.valid_res      <= ok;
      result.width_out      <= ok ? sum.width : '0;
      result.height_out     <= ok ? sum.height : '0;
      result.red_out        <= ok ? sum.red : '0;
      result.green_out      <= ok ? sum.green : '0;
      result.blue_out       <= ok ? sum.blue : '0;
      result.brightness_out <= ok ? sum.brightness : '0;
      result.mode_scroll    <= ok && sum.scroll;
      result.version_out    <= ok ? sum.version : '0;
    end
  end

endmodule

// ----- rtl/fixed_json_state_validator.sv -----
// ----------------------------------------------------------------------------
// fixed_json_state_validator
// Checks a byte stream against the fixed JSON state template and reports.
// ----------------------------------------------------------------------------
// Throughput: one payload word per cycle, held back only when a final word
//   meets a result that has not yet been taken.
// Result: a final word passes the input register, then the result register.
// Reset: rst (synchronous) empties the input and result registers, clears the
//   parse state and loads the limit registers with their defaults.
module fixed_json_state_validator
  import fjsv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  fjsv_in_if.sink    payload,
  fjsv_out_if.source result,
  fjsv_cfg_if.sink   cfg
);

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_last;
  logic       advance;
  logic       slot_free;
  fjsv_cfg_t  limits;
  fjsv_sum_t  sum;

  assign advance       = hold_valid && (!hold_last || slot_free);
  assign payload.ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (payload.valid && payload.ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (payload.valid && payload.ready) begin
      hold_byte <= payload.data_byte;
      hold_last <= payload.last_byte;
    end
  end

  fjsv_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .limits (limits)
  );

  fjsv_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (hold_byte),
    .last_byte (hold_last),
    .max_text  (limits.max_text),
    .sum       (sum)
  );

  fjsv_judge u_judge (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && hold_last),
    .sum       (sum),
    .limits    (limits),
    .slot_free (slot_free),
    .result    (result)
  );

endmodule

// ----- rtl/fjsv_checker.sv -----
// ----------------------------------------------------------------------------
// fjsv_checker
// Port-level checks on the result channel of the validator.
// ----------------------------------------------------------------------------
module fjsv_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        res_valid_res,
  input logic [7:0]  res_width,
  input logic [7:0]  res_height,
  input logic [7:0]  res_red,
  input logic [7:0]  res_green,
  input logic [7:0]  res_blue,
  input logic [7:0]  res_bright,
  input logic        res_scroll,
  input logic [63:0] res_version
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result word dropped while stalled");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_valid_res) && $stable(res_version) &&
      $stable(res_width) && $stable(res_height))
    else $error("result word changed while stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_valid_res |-> res_width == '0 && res_height == '0 &&
      res_red == '0 && res_green == '0 && res_blue == '0 && res_bright == '0 &&
      !res_scroll && res_version == '0)
    else $error("rejected payload carries nonzero fields");

  a_accept_dims: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_valid_res |-> res_width != '0 && res_height != '0)
    else $error("accepted payload with zero dimension");

endmodule

bind fixed_json_state_validator fjsv_checker u_fjsv_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .res_valid_res (result.valid_res),
  .res_width     (result.width_out),
  .res_height    (result.height_out),
  .res_red       (result.red_out),
  .res_green     (result.green_out),
  .res_blue      (result.blue_out),
  .res_bright    (result.brightness_out),
  .res_scroll    (result.mode_scroll),
  .res_version   (result.version_out)
);

// ----- tb/fjsv_check_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fjsv_check_pkg
// Scoreboard for the JSON state validator bench. It follows each accepted
// payload word through its own copy of the template parser and the limit
// registers, queues the report that a final word must produce, and compares
// every report from the block field by field with the oldest queued one.
// ----------------------------------------------------------------------------
package fjsv_check_pkg;
  import fjsv_pkg::*;

  localparam logic [7:0] MARK_NUM     = "#";
  localparam logic [7:0] MARK_TEXT    = "$";
  localparam logic [7:0] MARK_MODE    = "@";
  localparam logic [7:0] ASCII_QUOTE  = 8'h22;
  localparam logic [7:0] ASCII_BSLASH = 8'h5c;
  localparam logic [7:0] ASCII_DIGIT0 = "0";
  localparam logic [7:0] ASCII_DIGIT9 = "9";
  localparam logic [7:0] ASCII_SPACE  = 8'h20;
  localparam logic [7:0] ASCII_NUL    = 8'h00;
  localparam logic [63:0] U64_MAX     = '1;
  localparam int SMALL_SLOTS          = 6;
  localparam int MODE_WORD_LEN        = 6;
  localparam int LOGGED_MISMATCHES    = 10;

  typedef struct packed {
    logic        ok;
    logic [7:0]  wid;
    logic [7:0]  hgt;
    logic [7:0]  red;
    logic [7:0]  grn;
    logic [7:0]  blu;
    logic [7:0]  bri;
    logic        scroll;
    logic [63:0] version;
  } state_report_t;

  class state_scoreboard;
    string layout;
    string word_static;
    string word_scroll;
    string escapes;

    logic [7:0]  lim_dim;
    logic [15:0] lim_cells;
    logic [7:0]  lim_bright;
    logic [11:0] lim_text;

    int          pos;
    logic [63:0] acc;
    bit          have_digit;
    logic [7:0]  fields [SMALL_SLOTS];
    logic [63:0] version;
    int          text_len;
    bit          esc_open;
    int          word_len;
    logic [1:0]  word_hits;
    bit          failed;
    bit          ended;

    state_report_t expected_reports[$];
    int words_noted;
    int reports_noted;
    int mismatches;

    function new();
      layout = {"{\"type\":\"state\",\"width\":#,\"height\":#,\"text\":\"$,",
                "\"color\":[#,#,#],\"brightness\":#,\"mode\":\"@,\"version\":#}"};
      word_static = "static";
      word_scroll = "scroll";
      escapes = "\"\\/bfnrt";
      lim_dim = RST_MAX_DIM;
      lim_cells = RST_MAX_CELLS;
      lim_bright = RST_MAX_BRIGHT;
      lim_text = RST_MAX_TEXT;
      words_noted = 0;
      reports_noted = 0;
      mismatches = 0;
      clear_payload();
    endfunction

    function void write_limit(cfg_reg_t idx, logic [15:0] data);
      case (idx)
        REG_MAX_DIM: lim_dim = data[7:0];
        REG_MAX_CELLS: lim_cells = data;
        REG_MAX_BRIGHT: lim_bright = data[7:0];
        REG_MAX_TEXT: lim_text = data[11:0];
        default: ;
      endcase
    endfunction

    function void clear_payload();
      pos = 0;
      acc = '0;
      have_digit = 1'b0;
      foreach (fields[i]) fields[i] = '0;
      version = '0;
      text_len = 0;
      esc_open = 1'b0;
      word_len = 0;
      word_hits = 2'b11;
      failed = 1'b0;
      ended = 1'b0;
    endfunction

    function void take_number();
      int slot;
      slot = 0;
      for (int i = 0; i < pos && i < layout.len(); i++) begin
        if (layout[i] == MARK_NUM) slot++;
      end
      if (slot < SMALL_SLOTS) begin
        if (acc > 64'd255) failed = 1'b1;
        else fields[slot] = acc[7:0];
      end else begin
        version = acc;
      end
      acc = '0;
      have_digit = 1'b0;
    endfunction

    function bit escape_ok(logic [7:0] b);
      for (int i = 0; i < escapes.len(); i++) begin
        if (b == escapes[i]) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void count_text();
      text_len++;
      if (text_len > int'(lim_text)) failed = 1'b1;
    endfunction

    function void parse_byte(logic [7:0] b);
      logic [7:0]  t;
      logic [63:0] d;
      if (failed) return;
      if (pos >= layout.len()) begin
        failed = 1'b1;
        return;
      end
      t = layout[pos];
      if (t == MARK_NUM) begin
        if (b >= ASCII_DIGIT0 && b <= ASCII_DIGIT9) begin
          d = 64'(b) - 64'(ASCII_DIGIT0);
          if (acc > (U64_MAX - d) / 64'd10) begin
            failed = 1'b1;
            return;
          end
          acc = acc * 64'd10 + d;
          have_digit = 1'b1;
          return;
        end
        if (!have_digit) begin
          failed = 1'b1;
          return;
        end
        take_number();
        if (failed) return;
        pos++;
        t = layout[pos];
      end else if (t == MARK_TEXT) begin
        if (esc_open) begin
          esc_open = 1'b0;
          if (!escape_ok(b)) failed = 1'b1;
          else count_text();
        end else if (b == ASCII_QUOTE) begin
          pos++;
        end else if (b < ASCII_SPACE) begin
          failed = 1'b1;
        end else if (b == ASCII_BSLASH) begin
          esc_open = 1'b1;
        end else begin
          count_text();
        end
        return;
      end else if (t == MARK_MODE) begin
        if (b == ASCII_QUOTE) begin
          if (word_len == MODE_WORD_LEN && word_hits != 2'b00) pos++;
          else failed = 1'b1;
          return;
        end
        if (word_len >= MODE_WORD_LEN) begin
          failed = 1'b1;
          return;
        end
        if (b != word_static[word_len]) word_hits[0] = 1'b0;
        if (b != word_scroll[word_len]) word_hits[1] = 1'b0;
        word_len++;
        return;
      end
      if (b == t) pos++;
      else failed = 1'b1;
    endfunction

    function void note_word(logic [7:0] b, logic last);
      int w;
      int h;
      int br;
      bit ok;
      state_report_t rep;
      words_noted++;
      if (!ended) begin
        if (b == ASCII_NUL) ended = 1'b1;
        else parse_byte(b);
      end
      if (!last) return;
      w = int'(fields[0]);
      h = int'(fields[1]);
      br = int'(fields[5]);
      ok = !failed && pos == layout.len() &&
           w >= 1 && w <= int'(lim_dim) && h >= 1 && h <= int'(lim_dim) &&
           w * h <= int'(lim_cells) && br <= int'(lim_bright);
      rep = '0;
      if (ok) begin
        rep.ok = 1'b1;
        rep.wid = fields[0];
        rep.hgt = fields[1];
        rep.red = fields[2];
        rep.grn = fields[3];
        rep.blu = fields[4];
        rep.bri = fields[5];
        rep.scroll = word_hits[1];
        rep.version = version;
      end
      expected_reports.push_back(rep);
      reports_noted++;
      clear_payload();
    endfunction

    function string show(state_report_t r);
      return $sformatf("ok=%0b w=%0d h=%0d rgb=%0d,%0d,%0d br=%0d scroll=%0b ver=%0d",
                       r.ok, r.wid, r.hgt, r.red, r.grn, r.blu, r.bri, r.scroll,
                       r.version);
    endfunction

    function void check_report(state_report_t got);
      state_report_t want;
      if (expected_reports.size() == 0) begin
        if (mismatches < LOGGED_MISMATCHES) $display("unexpected report: %s", show(got));
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      if (got !== want) begin
        if (mismatches < LOGGED_MISMATCHES) begin
          $display("report mismatch\n  expected %s\n  actual   %s", show(want), show(got));
        end
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

endpackage

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Bench for fixed_json_state_validator. Sends directed payloads for the
// template edge cases, then random payloads (mostly well formed with random
// fields, some damaged, some noise) under several limit settings, with random
// gaps on the payload side and random stalls on the report side.
// ----------------------------------------------------------------------------
module tb;
  import fjsv_pkg::*;
  import fjsv_check_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;

  typedef logic [7:0] word_q_t[$];

  logic clk;
  logic rst;
  bit   steady;
  bit   hold_request;

  state_scoreboard sb = new();

  fjsv_in_if  pin ();
  fjsv_out_if pout ();
  fjsv_cfg_if pcfg ();

  fixed_json_state_validator u_top (
    .clk(clk),
    .rst(rst),
    .payload(pin),
    .result(pout),
    .cfg(pcfg)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #18_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  initial begin : report_sink
    int stall_left;
    int hold_left;
    state_report_t got;
    stall_left = 0;
    hold_left = 0;
    pout.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pout.valid && pout.ready) begin
        got.ok = pout.valid_res;
        got.wid = pout.width_out;
        got.hgt = pout.height_out;
        got.red = pout.red_out;
        got.grn = pout.green_out;
        got.blu = pout.blue_out;
        got.bri = pout.brightness_out;
        got.scroll = pout.mode_scroll;
        got.version = pout.version_out;
        sb.check_report(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        pout.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        pout.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pout.ready <= 1'b0;
      end else if (steady) begin
        pout.ready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        pout.ready <= (stall_left == 0);
      end
    end
  end

  task automatic put_word(input logic [7:0] b, input logic last);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      pin.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pin.valid <= 1'b1;
    pin.data_byte <= b;
    pin.last_byte <= last;
    @(posedge clk);
    while (!pin.ready) @(posedge clk);
    sb.note_word(b, last);
  endtask

  task automatic send_payload(input word_q_t q);
    foreach (q[i]) put_word(q[i], i == q.size() - 1);
  endtask

  function automatic word_q_t to_words(string s);
    word_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  task automatic send_text(input string s);
    send_payload(to_words(s));
  endtask

  // hold until the block has drained, then let it settle
  task automatic settle();
    pin.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input cfg_reg_t idx, input logic [15:0] data);
    pcfg.valid <= 1'b1;
    pcfg.index <= idx;
    pcfg.data <= data;
    @(posedge clk);
    while (!pcfg.ready) @(posedge clk);
    sb.write_limit(idx, data);
  endtask

  task automatic set_limits(input logic [7:0] dim, input logic [15:0] cells,
                            input logic [7:0] bright, input logic [11:0] text);
    settle();
    write_limit(REG_MAX_DIM, {8'($urandom), dim});
    write_limit(REG_MAX_CELLS, cells);
    write_limit(REG_MAX_BRIGHT, {8'($urandom), bright});
    write_limit(REG_MAX_TEXT, {4'($urandom), text});
    pcfg.valid <= 1'b0;
  endtask

  function automatic string json_text(string w, string h, string txt, string r,
                                      string g, string b, string br, string mode,
                                      string ver);
    return {"{\"type\":\"state\",\"width\":", w, ",\"height\":", h, ",\"text\":\"", txt,
            "\",\"color\":[", r, ",", g, ",", b, "],\"brightness\":", br,
            ",\"mode\":\"", mode, "\",\"version\":", ver, "}"};
  endfunction

  function automatic string pick_field(int lim, int lo);
    int r;
    int top;
    r = $urandom_range(0, 99);
    top = (lim < lo) ? lo : lim;
    if (r < 8) return "0";
    if (r < 18) return $sformatf("%0d", lim);
    if (r < 26) return $sformatf("%0d", lim + 1);
    if (r < 31) return $sformatf("%0d", $urandom_range(256, 999));
    if (r < 35) return $sformatf("%04d", $urandom_range(0, 255));
    if (r < 37) return "";
    return $sformatf("%0d", $urandom_range(lo, top));
  endfunction

  function automatic string pick_color();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return "255";
    if (r < 12) return "0";
    if (r < 16) return $sformatf("%0d", $urandom_range(256, 999));
    if (r < 19) return $sformatf("%03d", $urandom_range(0, 255));
    if (r < 20) return "";
    return $sformatf("%0d", $urandom_range(0, 255));
  endfunction

  function automatic string pick_version();
    int r;
    logic [63:0] v;
    r = $urandom_range(0, 99);
    v = {$urandom, $urandom};
    if (r < 10) return "0";
    if (r < 20) return "18446744073709551615";
    if (r < 25) return "18446744073709551616";
    if (r < 28) return "99999999999999999999";
    if (r < 60) return $sformatf("%0d", v);
    return $sformatf("%0d", $urandom_range(0, 99999));
  endfunction

  function automatic string pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return "static";
    if (r < 90) return "scroll";
    case ($urandom_range(0, 5))
      0: return "statics";
      1: return "stat";
      2: return "scrolL";
      3: return "scrol\001";
      4: return "";
      default: return "stbtic";
    endcase
  endfunction

  function automatic string pick_text(int lim);
    string s;
    int n;
    int r;
    logic [7:0] c;
    s = "";
    if (lim <= 16 && $urandom_range(0, 1) == 1) n = lim + $urandom_range(0, 1);
    else n = $urandom_range(0, 8);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        c = 8'($urandom_range(32, 126));
        if (c == ASCII_QUOTE || c == ASCII_BSLASH) c = "a";
        s = $sformatf("%s%c", s, c);
      end else if (r < 80) begin
        s = $sformatf("%s%c%c", s, ASCII_BSLASH, sb.escapes[$urandom_range(0, 7)]);
      end else if (r < 95) begin
        s = $sformatf("%s%c", s, 8'($urandom_range(128, 255)));
      end else if (r < 97) begin
        s = $sformatf("%s%c", s, 8'($urandom_range(1, 31)));
      end else begin
        s = $sformatf("%s%c%c", s, ASCII_BSLASH, 8'($urandom_range(32, 126)));
      end
    end
    return s;
  endfunction

  function automatic word_q_t make_payload();
    word_q_t q;
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
      return q;
    end
    q = to_words(json_text(pick_field(sb.lim_dim, 1), pick_field(sb.lim_dim, 1),
                           pick_text(sb.lim_text), pick_color(), pick_color(),
                           pick_color(), pick_field(sb.lim_bright, 0), pick_mode(),
                           pick_version()));
    r = $urandom_range(0, 99);
    if (r < 6) begin
      q = q[0 : $urandom_range(0, q.size() - 2)];
    end else if (r < 12) begin
      q.insert($urandom_range(0, q.size() - 1), ASCII_NUL);
    end else if (r < 16) begin
      q.push_back(8'($urandom_range(1, 255)));
    end else if (r < 22) begin
      q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (r < 26) begin
      q.push_back(ASCII_NUL);
      repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
    end
    return q;
  endfunction

  task automatic run_random(input int min_words, input int min_reports);
    int w0;
    int r0;
    w0 = sb.words_noted;
    r0 = sb.reports_noted;
    while (sb.words_noted - w0 < min_words || sb.reports_noted - r0 < min_reports) begin
      send_payload(make_payload());
    end
  endtask

  initial begin : stimulus
    string good;
    word_q_t q;
    rst <= 1'b1;
    pin.valid <= 1'b0;
    pin.data_byte <= '0;
    pin.last_byte <= 1'b0;
    pcfg.valid <= 1'b0;
    pcfg.index <= REG_MAX_DIM;
    pcfg.data <= '0;
    steady = 1'b0;
    hold_request = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    good = json_text("8", "8", "hi", "255", "0", "128", "100", "static", "0");
    send_text(good);
    send_text(json_text("128", "32", "a", "0", "255", "1", "0", "scroll",
                        "18446744073709551615"));
    send_text(json_text("1", "1", "", "0", "0", "0", "0", "static", "18446744073709551616"));
    send_text(json_text("8", "8", "\\\"\\\\\\/\\b\\f\\n\\r\\t\377\177 ", "1", "2", "3",
                        "4", "scroll", "77"));
    send_text(json_text("8", "8", "a\\x", "1", "2", "3", "4", "static", "5"));
    send_text("{\"type\":\"state\",\"width\":8,\"height\":8,\"text\":\"a\\");
    q = to_words(good);
    q.insert(40, ASCII_NUL);
    send_payload(q);
    q = to_words(good);
    q.push_back(ASCII_NUL);
    q.push_back(8'hff);
    q.push_back(8'h41);
    send_payload(q);
    q = {};
    q.push_back(ASCII_NUL);
    send_payload(q);
    q = {};
    q.push_back(8'hff);
    send_payload(q);

    set_limits(8'd1, 16'd1, 8'd0, 12'd0);
    run_random(40, 1);

    set_limits(8'd255, 16'd65535, 8'd255, 12'd4095);
    // fill the block while the report side holds off
    hold_request = 1'b1;
    steady = 1'b1;
    repeat (24) send_text("}");
    steady = 1'b0;
    run_random(40, 1);

    set_limits(8'd16, 16'd200, 8'd50, 12'd4);
    send_text(json_text("8", "8", "abcde", "1", "2", "3", "4", "static", "5"));
    run_random(40, 1);

    set_limits(8'($urandom), 16'($urandom), 8'($urandom), 12'($urandom));
    steady = 1'b1;
    run_random(40, 1);
    steady = 1'b0;

    set_limits(8'd0, 16'd0, 8'd255, 12'd4095);
    run_random(40, 1);

    set_limits(RST_MAX_DIM, RST_MAX_CELLS, RST_MAX_BRIGHT, RST_MAX_TEXT);
    run_random(40, 1);

    settle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/fjsv_pkg.sv
rtl/fjsv_if.sv
rtl/fjsv_cfg.sv
rtl/fjsv_parser.sv
rtl/fjsv_judge.sv
rtl/fixed_json_state_validator.sv
rtl/fjsv_checker.sv
tb/fjsv_check_pkg.sv
tb/tb.sv
